// ===== src/arp_cache_responder_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef ARP_CACHE_RESPONDER_CORE_ASSERT_SVH
`define ARP_CACHE_RESPONDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ARPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("arpc assertion failed");

// Next-cycle implication, disabled during reset.
`define ARPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("arpc assertion failed");

`endif

// ===== src/arpc_pkg.sv =====
package arpc_pkg;

   localparam int CacheEntries = 8;
   localparam int CacheIdxW    = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;

   // APB register map: 64-bit registers on 8-byte spacing
   localparam int CsrAddrW = 5;
   localparam logic [1:0] REG_OUR_IP       = 2'd0;
   localparam logic [1:0] REG_OUR_MAC      = 2'd1;
   localparam logic [1:0] REG_INTERFACE_UP = 2'd2;

   // request operations
   localparam logic [1:0] OP_RECEIVE = 2'd0;
   localparam logic [1:0] OP_LOOKUP  = 2'd1;
   localparam logic [1:0] OP_SEND    = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_LOOKUP = 2'd1;
   localparam logic [1:0] KIND_FRAME  = 2'd2;

   // ARP protocol values
   localparam logic [15:0] ArpMinLen   = 16'd28;
   localparam logic [15:0] HwEthernet  = 16'h0001;
   localparam logic [15:0] ProtoIpv4   = 16'h0800;
   localparam logic [15:0] ArpOpRequest = 16'd1;
   localparam logic [1:0]  FrameOpRequest = 2'd1;
   localparam logic [1:0]  FrameOpReply   = 2'd2;
   localparam logic [47:0] BcastMac    = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [31:0] our_ip;
      logic [47:0] our_mac;
      logic        interface_up;
   } cfg_type;

   typedef struct packed {
      logic        en;
      logic [31:0] ip;
      logic [47:0] mac;
   } store_type;

   typedef struct packed {
      logic        hit;
      logic [47:0] mac;
   } lookup_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] payload_length;
      logic [15:0] hw_type;
      logic [15:0] proto_type;
      logic [15:0] arp_opcode;
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
      logic [31:0] tgt_ip;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic        lookup_hit;
      logic [47:0] lookup_mac;
      logic [47:0] frame_dest_mac;
      logic [1:0]  frame_opcode;
      logic [47:0] frame_sender_mac;
      logic [31:0] frame_sender_ip;
      logic [47:0] frame_target_mac;
      logic [31:0] frame_tgt_ip;
   } rsp_type;

endpackage

// ===== src/arpc_csr.sv =====
module arpc_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [arpc_pkg::CsrAddrW-1:0] paddr,
   input  logic [63:0]                  pwdata,
   output logic [63:0]                  prdata,
   output logic                         pready,
   output arpc_pkg::cfg_type            cfg
);

   arpc_pkg::cfg_type cfg_ff;
   logic [1:0]        reg_idx;
   logic              wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:3];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            arpc_pkg::REG_OUR_IP:       cfg_ff.our_ip       <= pwdata[31:0];
            arpc_pkg::REG_OUR_MAC:      cfg_ff.our_mac      <= pwdata[47:0];
            arpc_pkg::REG_INTERFACE_UP: cfg_ff.interface_up <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         arpc_pkg::REG_OUR_IP:       prdata = {32'd0, cfg_ff.our_ip};
         arpc_pkg::REG_OUR_MAC:      prdata = {16'd0, cfg_ff.our_mac};
         arpc_pkg::REG_INTERFACE_UP: prdata = {63'd0, cfg_ff.interface_up};
         default:                    prdata = '0;
      endcase
   end

endmodule

// ===== src/arpc_cache.sv =====
module arpc_cache (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [31:0]           key_ip,
   input  arpc_pkg::store_type   store,
   output arpc_pkg::lookup_type  lookup
);

   localparam int N = arpc_pkg::CacheEntries;
   localparam int W = arpc_pkg::CacheIdxW;

   logic [31:0]  entry_ip_ff  [N];
   logic [47:0]  entry_mac_ff [N];
   logic [N-1:0] valid_ff;

   logic [N-1:0] match;
   logic         any_match;
   logic         any_free;
   logic [W-1:0] match_idx;
   logic [W-1:0] free_idx;
   logic [W-1:0] store_idx;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         match[i] = valid_ff[i] && (entry_ip_ff[i] == key_ip);
      end
   end

   // lowest-numbered hit and lowest-numbered free slot
   always_comb begin
      match_idx = '0;
      free_idx  = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (match[i]) begin
            match_idx = W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = W'(i);
         end
      end
   end

   assign any_match = |match;
   assign any_free  = ~&valid_ff;

   always_comb begin
      priority if (any_match) begin
         store_idx = match_idx;
      end else if (any_free) begin
         store_idx = free_idx;
      end else begin
         store_idx = '0;
      end
   end

   assign lookup.hit = any_match;
   assign lookup.mac = any_match ? entry_mac_ff[match_idx] : 48'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (store.en) begin
         valid_ff[store_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (store.en) begin
         entry_ip_ff[store_idx]  <= store.ip;
         entry_mac_ff[store_idx] <= store.mac;
      end
   end

endmodule

// ===== src/arp_cache_responder_core.sv =====
// Channel  | Direction | Handshake            | Payload
// req      | in        | req_valid/req_stall  | operation, ARP fields, tgt_ip
// rsp      | out       | rsp_valid/rsp_stall  | result kind, lookup answer, frame
// csr      | APB       | psel/penable/pready  | our_ip, our_mac, interface_up
//
// One item per cycle while rsp_stall does not hold the result; an accepted item passes through
// the input register, then the result register (the cache compare sits between them).
// The cache is written at the edge where the item moves into the result register.
// Reset clears the CSR registers, the cache valid bits and both pipeline valids.
// req_stall rises only while both registers are full and rsp_stall is high.
module arp_cache_responder_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_operation,
   input  logic [15:0]                   req_payload_length,
   input  logic [15:0]                   req_hw_type,
   input  logic [15:0]                   req_proto_type,
   input  logic [15:0]                   req_arp_opcode,
   input  logic [47:0]                   req_sender_mac,
   input  logic [31:0]                   req_sender_ip,
   input  logic [31:0]                   req_tgt_ip,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_result_kind,
   output logic                          rsp_lookup_hit,
   output logic [47:0]                   rsp_lookup_mac,
   output logic [47:0]                   rsp_frame_dest_mac,
   output logic [1:0]                    rsp_frame_opcode,
   output logic [47:0]                   rsp_frame_sender_mac,
   output logic [31:0]                   rsp_frame_sender_ip,
   output logic [47:0]                   rsp_frame_target_mac,
   output logic [31:0]                   rsp_frame_tgt_ip,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [arpc_pkg::CsrAddrW-1:0] paddr,
   input  logic [63:0]                   pwdata,
   output logic [63:0]                   prdata,
   output logic                          pready
);

   arpc_pkg::cfg_type    cfg;
   arpc_pkg::store_type  store;
   arpc_pkg::lookup_type lookup;
   arpc_pkg::req_type    req_in;
   arpc_pkg::req_type    s1_ff;
   arpc_pkg::rsp_type    rsp_in;
   arpc_pkg::rsp_type    rsp_ff;

   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        s1_take;
   logic        req_load;
   logic        rx_ok;
   logic [31:0] key_ip;

   arpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   arpc_cache u_cache (
      .clock  (clock),
      .reset  (reset),
      .key_ip (key_ip),
      .store  (store),
      .lookup (lookup)
   );

   assign req_in = '{
      operation:      req_operation,
      payload_length: req_payload_length,
      hw_type:        req_hw_type,
      proto_type:     req_proto_type,
      arp_opcode:     req_arp_opcode,
      sender_mac:     req_sender_mac,
      sender_ip:      req_sender_ip,
      tgt_ip:         req_tgt_ip
   };

   // the input register moves on whenever the result register can take it
   assign s1_take   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_take;
   assign req_load  = req_valid && !req_stall;

   assign s1_valid_in  = req_load ? 1'b1 : (s1_take ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_take ? s1_valid_ff : rsp_valid_ff;

   assign rx_ok = (s1_ff.payload_length >= arpc_pkg::ArpMinLen) &&
                  (s1_ff.hw_type == arpc_pkg::HwEthernet) &&
                  (s1_ff.proto_type == arpc_pkg::ProtoIpv4);

   assign key_ip = (s1_ff.operation == arpc_pkg::OP_LOOKUP) ? s1_ff.tgt_ip
                                                            : s1_ff.sender_ip;

   assign store.en  = s1_valid_ff && s1_take && rx_ok &&
                      (s1_ff.operation == arpc_pkg::OP_RECEIVE);
   assign store.ip  = s1_ff.sender_ip;
   assign store.mac = s1_ff.sender_mac;

   always_comb begin
      rsp_in = '0;
      unique case (s1_ff.operation)
         arpc_pkg::OP_RECEIVE: begin
            if (rx_ok && (s1_ff.arp_opcode == arpc_pkg::ArpOpRequest) &&
                (s1_ff.tgt_ip == cfg.our_ip) && cfg.interface_up) begin
               rsp_in.result_kind      = arpc_pkg::KIND_FRAME;
               rsp_in.frame_dest_mac   = s1_ff.sender_mac;
               rsp_in.frame_opcode     = arpc_pkg::FrameOpReply;
               rsp_in.frame_sender_mac = cfg.our_mac;
               rsp_in.frame_sender_ip  = cfg.our_ip;
               rsp_in.frame_target_mac = s1_ff.sender_mac;
               rsp_in.frame_tgt_ip     = s1_ff.sender_ip;
            end
         end
         arpc_pkg::OP_LOOKUP: begin
            rsp_in.result_kind = arpc_pkg::KIND_LOOKUP;
            rsp_in.lookup_hit  = lookup.hit;
            rsp_in.lookup_mac  = lookup.mac;
         end
         arpc_pkg::OP_SEND: begin
            if (cfg.interface_up) begin
               rsp_in.result_kind      = arpc_pkg::KIND_FRAME;
               rsp_in.frame_dest_mac   = arpc_pkg::BcastMac;
               rsp_in.frame_opcode     = arpc_pkg::FrameOpRequest;
               rsp_in.frame_sender_mac = cfg.our_mac;
               rsp_in.frame_sender_ip  = cfg.our_ip;
               rsp_in.frame_tgt_ip     = s1_ff.tgt_ip;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load) begin
         s1_ff <= req_in;
      end
      if (s1_take && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_kind      = rsp_ff.result_kind;
   assign rsp_lookup_hit       = rsp_ff.lookup_hit;
   assign rsp_lookup_mac       = rsp_ff.lookup_mac;
   assign rsp_frame_dest_mac   = rsp_ff.frame_dest_mac;
   assign rsp_frame_opcode     = rsp_ff.frame_opcode;
   assign rsp_frame_sender_mac = rsp_ff.frame_sender_mac;
   assign rsp_frame_sender_ip  = rsp_ff.frame_sender_ip;
   assign rsp_frame_target_mac = rsp_ff.frame_target_mac;
   assign rsp_frame_tgt_ip     = rsp_ff.frame_tgt_ip;

endmodule

// ===== src/arpc_checker.sv =====
`include "arp_cache_responder_core_assert.svh"

module arpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_result_kind,
   input logic        rsp_lookup_hit,
   input logic [47:0] rsp_lookup_mac,
   input logic [47:0] rsp_frame_dest_mac,
   input logic [1:0]  rsp_frame_opcode,
   input logic [47:0] rsp_frame_target_mac,
   input logic [31:0] rsp_frame_tgt_ip
);

   // frame fields stay zero on anything that is not a frame
   `ARPC_ASSERT_NOW(a_frame_clear, clock, reset,
      rsp_valid && (rsp_result_kind != arpc_pkg::KIND_FRAME),
      (rsp_frame_opcode == 2'd0) && (rsp_frame_dest_mac == 48'd0) &&
      (rsp_frame_target_mac == 48'd0) && (rsp_frame_tgt_ip == 32'd0))

   // a miss or a non-lookup result carries no MAC
   `ARPC_ASSERT_NOW(a_lookup_clear, clock, reset,
      rsp_valid && !rsp_lookup_hit, rsp_lookup_mac == 48'd0)

   // broadcast requests carry an all-zero target MAC
   `ARPC_ASSERT_NOW(a_request_shape, clock, reset,
      rsp_valid && (rsp_result_kind == arpc_pkg::KIND_FRAME) &&
      (rsp_frame_opcode == arpc_pkg::FrameOpRequest),
      (rsp_frame_dest_mac == arpc_pkg::BcastMac) && (rsp_frame_target_mac == 48'd0))

   // a stalled result holds
   `ARPC_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_result_kind) && $stable(rsp_frame_tgt_ip))

endmodule

bind arp_cache_responder_core arpc_checker u_arpc_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_result_kind      (rsp_result_kind),
   .rsp_lookup_hit       (rsp_lookup_hit),
   .rsp_lookup_mac       (rsp_lookup_mac),
   .rsp_frame_dest_mac   (rsp_frame_dest_mac),
   .rsp_frame_opcode     (rsp_frame_opcode),
   .rsp_frame_target_mac (rsp_frame_target_mac),
   .rsp_frame_tgt_ip     (rsp_frame_tgt_ip)
);
